### design/csbb_pkg.sv
// Shared types and constants for the circular sample buffer with bounds tracking.
`timescale 1ns / 1ps
`default_nettype none

package csbb_pkg;

  localparam int LEN_W  = 11;
  localparam int DATA_W = 32;

  // Operation codes carried by in_kind
  typedef enum logic [1:0] {
    KIND_PUT     = 2'd0,
    KIND_READ    = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  // Register word indexes (byte address 4*i)
  localparam logic [1:0] REG_ADDRESSING = 2'd0;
  localparam logic [1:0] REG_LENGTH     = 2'd1;
  localparam logic [1:0] REG_PERIOD     = 2'd2;
  localparam logic [1:0] REG_START      = 2'd3;

  typedef struct packed {
    logic                     addressing_circular;
    logic [LEN_W-1:0]         buffer_length;
    logic [30:0]              sample_period;
    logic signed [DATA_W-1:0] start_time;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic take;        // input word accepted this cycle
    logic put_do;      // old point data back from the store, commit the put
    logic rd_do;       // read data back from the store
    logic scan_start;  // arm the y rescan
    logic scan_run;    // rescan in progress
    logic sweep;       // zero one store entry
    logic load_out;    // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic sweep_last;
  } sts_t;

endpackage

`default_nettype wire

### design/circular_sample_buffer_bounds.sv
// Top level: register port, controller and datapath of the circular sample buffer.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                    Contents
// in_*      in_valid / in_stall          kind, sample_value, time_step, read_index
// out_*     out_valid / out_stall        point x/y, bounds, stored_count, bounds_empty
// APB       psel, penable, pwrite/pready addressing, length, period, start time
//
// Put and read words each do one store read, then the update or result.
// A put that evicts a y extreme adds a rescan over the y store.
// Clear zeroes one store row per cycle.
// After reset the block sweeps both stores with in_stall high.
// A finished result waits in the output register; the next word is taken meanwhile.

module circular_sample_buffer_bounds #(
  parameter int DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input words
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_kind,
  input  logic signed [csbb_pkg::DATA_W-1:0] in_sample_value,
  input  logic signed [csbb_pkg::DATA_W-1:0] in_time_step,
  input  logic [9:0]                         in_read_index,
  // result words
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [csbb_pkg::DATA_W-1:0] out_point_x,
  output logic signed [csbb_pkg::DATA_W-1:0] out_point_y,
  output logic signed [csbb_pkg::DATA_W-1:0] out_bound_left,
  output logic signed [csbb_pkg::DATA_W-1:0] out_bound_right,
  output logic signed [csbb_pkg::DATA_W-1:0] out_bound_min_y,
  output logic signed [csbb_pkg::DATA_W-1:0] out_bound_max_y,
  output logic [csbb_pkg::LEN_W-1:0]         out_stored_count,
  output logic                               out_bounds_empty,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import csbb_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cfg_wr;
  logic cfg_len_wr;
  cmd_t cmd;
  sts_t sts;

  // Register writes complete on the access phase; no wait states
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_len_wr = cfg_wr && (paddr[3:2] == REG_LENGTH);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ADDRESSING: cfg_nxt.addressing_circular = pwdata[0];
        REG_LENGTH:     cfg_nxt.buffer_length       = pwdata[LEN_W-1:0];
        REG_PERIOD:     cfg_nxt.sample_period       = pwdata[30:0];
        REG_START:      cfg_nxt.start_time          = pwdata;
        default:        cfg_nxt                     = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.addressing_circular <= 1'b1;
      cfg_r.buffer_length       <= LEN_W'(1024);
      cfg_r.sample_period       <= 31'd65536;
      cfg_r.start_time          <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the register selected by the word address
  always_comb begin
    unique case (paddr[3:2])
      REG_ADDRESSING: prdata = {31'b0, cfg_r.addressing_circular};
      REG_LENGTH:     prdata = {{(32-LEN_W){1'b0}}, cfg_r.buffer_length};
      REG_PERIOD:     prdata = {1'b0, cfg_r.sample_period};
      REG_START:      prdata = cfg_r.start_time;
      default:        prdata = '0;
    endcase
  end

  csbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  csbb_dp #(.DEPTH(DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cfg_len_wr       (cfg_len_wr),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_sample_value  (in_sample_value),
    .in_time_step     (in_time_step),
    .in_read_index    (in_read_index),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_bound_left   (out_bound_left),
    .out_bound_right  (out_bound_right),
    .out_bound_min_y  (out_bound_min_y),
    .out_bound_max_y  (out_bound_max_y),
    .out_stored_count (out_stored_count),
    .out_bounds_empty (out_bounds_empty)
  );

endmodule

`default_nettype wire

### design/csbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module csbb_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/csbb_ctrl.sv
// Controller state machine: sequences puts, reads, rescans, store sweeps and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module csbb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_kind,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  csbb_pkg::sts_t  sts,
  output csbb_pkg::cmd_t  cmd
);

  import csbb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUT,
    S_RD,
    S_SCAN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   reply_r, reply_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (kind_t'(in_kind))
            KIND_PUT:     state_nxt = S_PUT;
            KIND_READ:    state_nxt = S_RD;
            KIND_CLEAR: begin
              state_nxt = S_CLEAR;
              reply_nxt = 1'b1;
            end
            KIND_RESTART: state_nxt = S_OUT;
            default:      state_nxt = S_OUT;
          endcase
        end
      end
      S_PUT: begin
        cmd.put_do = 1'b1;
        if (sts.need_scan) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RD: begin
        cmd.rd_do = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = reply_r ? S_OUT : S_IDLE;
          reply_nxt = 1'b0;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      reply_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      reply_r     <= reply_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> out_free)
    else $error("result loaded over a stalled word");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_scan_follows_put: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |=> (state_r == S_SCAN) && !out_valid_nxt || (state_r == S_SCAN))
    else $error("rescan armed but not entered");
`endif

endmodule

`default_nettype wire

### design/csbb_dp.sv
// Datapath: point stores, write pointer, fill count, bounding box, rescan and result register.
`timescale 1ns / 1ps
`default_nettype none

module csbb_dp #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  csbb_pkg::cfg_t                    cfg,
  input  logic                              cfg_len_wr,
  input  csbb_pkg::cmd_t                    cmd,
  output csbb_pkg::sts_t                    sts,
  input  logic [1:0]                        in_kind,
  input  logic signed [csbb_pkg::DATA_W-1:0] in_sample_value,
  input  logic signed [csbb_pkg::DATA_W-1:0] in_time_step,
  input  logic [9:0]                        in_read_index,
  output logic signed [csbb_pkg::DATA_W-1:0] out_point_x,
  output logic signed [csbb_pkg::DATA_W-1:0] out_point_y,
  output logic signed [csbb_pkg::DATA_W-1:0] out_bound_left,
  output logic signed [csbb_pkg::DATA_W-1:0] out_bound_right,
  output logic signed [csbb_pkg::DATA_W-1:0] out_bound_min_y,
  output logic signed [csbb_pkg::DATA_W-1:0] out_bound_max_y,
  output logic [csbb_pkg::LEN_W-1:0]        out_stored_count,
  output logic                              out_bounds_empty
);

  import csbb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int IW = ((AW > LEN_W) ? AW : LEN_W) + 1;

  // Effective length and pointer arithmetic
  logic [LEN_W-1:0] len_eff;
  logic [IW-1:0]    len_i, wp_i, wp_inc, nwp_i, idx_i, rot_i, rot_w, rd_p, scan_i;
  logic             full, in_range, first, sat, scan_issue, evict_ext, empty_req;

  logic signed [33:0]       sum_x;
  logic signed [DATA_W-1:0] x_new, lo_new, hi_new, old_y, x_rd, x_rdata_s;

  // State
  logic [AW-1:0]            wp_r, wp_nxt;
  logic [LEN_W-1:0]         fill_r, fill_nxt;
  logic signed [DATA_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt, max_r, max_nxt;
  logic                     empty_r, empty_nxt;
  logic [LEN_W-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic                     scan_dv_r, scan_dv_nxt, scan_first_r, scan_first_nxt;
  logic [AW-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic signed [DATA_W-1:0] pt_x_r, pt_x_nxt, pt_y_r, pt_y_nxt;

  // Held item fields
  logic signed [DATA_W-1:0] y_in_r, step_in_r;
  logic                     in_range_r;

  // Result register
  logic signed [DATA_W-1:0] out_px_r, out_py_r, out_left_r, out_right_r, out_min_r, out_max_r;
  logic [LEN_W-1:0]         out_count_r;
  logic                     out_empty_r;

  // Store ports
  logic              ram_we, x_re, y_re;
  logic [AW-1:0]     ram_waddr, x_raddr, y_raddr;
  logic [DATA_W-1:0] x_wdata, y_wdata, x_rdata, y_rdata;

  csbb_ram #(.W(DATA_W), .D(DEPTH)) u_x_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (x_wdata),
    .re    (x_re),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  csbb_ram #(.W(DATA_W), .D(DEPTH)) u_y_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (y_wdata),
    .re    (y_re),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  // Length saturates to 1..DEPTH
  always_comb begin
    if (cfg.buffer_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(cfg.buffer_length) > 32'(DEPTH)) begin
      len_eff = LEN_W'(DEPTH);
    end else begin
      len_eff = cfg.buffer_length;
    end
  end

  assign len_i  = IW'(len_eff);
  assign wp_i   = IW'(wp_r);
  assign wp_inc = wp_i + IW'(1);
  assign nwp_i  = (wp_inc >= len_i) ? '0 : wp_inc;
  assign full   = (fill_r >= len_eff);
  assign first  = (fill_r == '0);

  // Logical to physical read index
  assign idx_i    = IW'(in_read_index);
  assign in_range = (idx_i < len_i);
  assign rot_i    = idx_i + wp_i;
  assign rot_w    = (rot_i >= len_i) ? (rot_i - len_i) : rot_i;
  assign rd_p     = (cfg.addressing_circular && full) ? rot_w : idx_i;
  assign scan_i   = IW'(scan_cnt_r);

  // Next x: step or sample period, saturate high
  assign sum_x = {{2{right_r[DATA_W-1]}}, right_r}
               + (step_in_r[DATA_W-1] ? {3'b000, cfg.sample_period}
                                      : {{2{step_in_r[DATA_W-1]}}, step_in_r});
  assign sat   = !sum_x[33] && (sum_x[32] || sum_x[31]);
  assign x_new = sat ? {1'b0, {(DATA_W-1){1'b1}}} : sum_x[DATA_W-1:0];

  assign lo_new    = (y_in_r < min_r) ? y_in_r : min_r;
  assign hi_new    = (y_in_r > max_r) ? y_in_r : max_r;
  assign old_y     = y_rdata;
  assign x_rdata_s = x_rdata;
  assign evict_ext = ((old_y <= lo_new) && (old_y < y_in_r))
                  || ((old_y >= hi_new) && (old_y > y_in_r));
  // With a single slot the new oldest point is the one just written
  assign x_rd      = (nwp_i == wp_i) ? x_new : x_rdata_s;

  assign scan_issue = cmd.scan_run && (scan_cnt_r < fill_r);
  assign empty_req  = cfg_len_wr
                   || (cmd.take && ((in_kind == KIND_CLEAR) || (in_kind == KIND_RESTART)));

  assign sts.need_scan  = !first && full && evict_ext;
  assign sts.scan_done  = cmd.scan_run && scan_dv_r && !scan_issue;
  assign sts.sweep_last = (clr_cnt_r == AW'(DEPTH - 1));

  // Store access
  assign ram_we    = cmd.sweep || cmd.put_do;
  assign ram_waddr = cmd.sweep ? clr_cnt_r : wp_r;
  assign x_wdata   = cmd.sweep ? '0 : (first ? cfg.start_time : x_new);
  assign y_wdata   = cmd.sweep ? '0 : y_in_r;
  assign x_re      = cmd.take;
  assign x_raddr   = (in_kind == KIND_PUT) ? nwp_i[AW-1:0] : rd_p[AW-1:0];
  assign y_re      = cmd.take || scan_issue;
  assign y_raddr   = cmd.scan_run ? scan_i[AW-1:0]
                   : ((in_kind == KIND_PUT) ? wp_r : rd_p[AW-1:0]);

  always_comb begin
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    min_nxt        = min_r;
    max_nxt        = max_r;
    empty_nxt      = empty_r;
    scan_cnt_nxt   = scan_cnt_r;
    scan_dv_nxt    = scan_dv_r;
    scan_first_nxt = scan_first_r;
    clr_cnt_nxt    = clr_cnt_r;
    pt_x_nxt       = pt_x_r;
    pt_y_nxt       = pt_y_r;

    if (cmd.sweep) begin
      clr_cnt_nxt = sts.sweep_last ? '0 : (clr_cnt_r + AW'(1));
    end

    if (cmd.take) begin
      pt_x_nxt = '0;
      pt_y_nxt = '0;
    end
    if (cmd.rd_do) begin
      pt_x_nxt = in_range_r ? signed'(x_rdata) : '0;
      pt_y_nxt = in_range_r ? signed'(y_rdata) : '0;
    end

    if (empty_req) begin
      wp_nxt    = '0;
      fill_nxt  = '0;
      left_nxt  = '0;
      right_nxt = '0;
      min_nxt   = '0;
      max_nxt   = '0;
      empty_nxt = 1'b1;
    end else if (cmd.put_do) begin
      wp_nxt = nwp_i[AW-1:0];
      if (first) begin
        fill_nxt  = LEN_W'(1);
        left_nxt  = cfg.start_time;
        right_nxt = cfg.start_time;
        min_nxt   = y_in_r;
        max_nxt   = y_in_r;
        empty_nxt = 1'b0;
      end else begin
        right_nxt = x_new;
        min_nxt   = lo_new;
        max_nxt   = hi_new;
        if (!full) begin
          fill_nxt = fill_r + LEN_W'(1);
        end else begin
          fill_nxt = len_eff;
          left_nxt = x_rd;
        end
      end
    end else if (cmd.scan_run) begin
      scan_cnt_nxt = scan_cnt_r + LEN_W'(scan_issue);
      scan_dv_nxt  = scan_issue;
      if (scan_dv_r) begin
        if (scan_first_r) begin
          min_nxt        = old_y;
          max_nxt        = old_y;
          scan_first_nxt = 1'b0;
        end else begin
          min_nxt = (old_y < min_r) ? old_y : min_r;
          max_nxt = (old_y > max_r) ? old_y : max_r;
        end
      end
    end

    if (cmd.scan_start) begin
      scan_cnt_nxt   = '0;
      scan_dv_nxt    = 1'b0;
      scan_first_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r         <= '0;
      fill_r       <= '0;
      left_r       <= '0;
      right_r      <= '0;
      min_r        <= '0;
      max_r        <= '0;
      empty_r      <= 1'b1;
      scan_cnt_r   <= '0;
      scan_dv_r    <= 1'b0;
      scan_first_r <= 1'b0;
      clr_cnt_r    <= '0;
    end else begin
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      min_r        <= min_nxt;
      max_r        <= max_nxt;
      empty_r      <= empty_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      scan_dv_r    <= scan_dv_nxt;
      scan_first_r <= scan_first_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_x_r <= pt_x_nxt;
    pt_y_r <= pt_y_nxt;
    if (cmd.take) begin
      y_in_r     <= in_sample_value;
      step_in_r  <= in_time_step;
      in_range_r <= in_range;
    end
    if (cmd.load_out) begin
      out_px_r    <= pt_x_nxt;
      out_py_r    <= pt_y_nxt;
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_min_r   <= min_nxt;
      out_max_r   <= max_nxt;
      out_count_r <= fill_nxt;
      out_empty_r <= empty_nxt;
    end
  end

  assign out_point_x      = out_px_r;
  assign out_point_y      = out_py_r;
  assign out_bound_left   = out_left_r;
  assign out_bound_right  = out_right_r;
  assign out_bound_min_y  = out_min_r;
  assign out_bound_max_y  = out_max_r;
  assign out_stored_count = out_count_r;
  assign out_bounds_empty = out_empty_r;

`ifndef NO_ASSERTIONS
  a_fill_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_eff)
    else $error("fill count beyond buffer length");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r == (fill_r == '0))
    else $error("empty flag disagrees with fill count");

  a_wp_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    wp_i < len_i)
    else $error("write position outside buffer length");
`endif

endmodule

`default_nettype wire
